### hw/rtl/coefficient_quantizer_8x8_macros.svh
// Assertion macros for the 8x8 coefficient quantizer checker.
// Needs nothing else; included by the checker file.
`ifndef COEFFICIENT_QUANTIZER_8X8_MACROS_SVH
`define COEFFICIENT_QUANTIZER_8X8_MACROS_SVH

// Property checked on the rising clock, off while reset is high.
`define CQ8_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen on a rising clock.
`define CQ8_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### hw/rtl/cq8_pkg.sv
// Shared types, codes and constant tables of the 8x8 coefficient quantizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cq8_pkg;

   localparam logic CMD_QUANT   = 1'b0;
   localparam logic CMD_DEQUANT = 1'b1;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;
   localparam int COEFF_W     = 24;
   localparam int RESULT_W    = 36;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_QP          = 4'd0,
      CSR_H_BLOCKNESS = 4'd1,
      CSR_V_BLOCKNESS = 4'd2,
      CSR_USE_MATRIX  = 4'd3
   } cq8_csr_type;

   // qp resets to 26: remainder 2, shift 4
   localparam logic [2:0] QP_REM_RESET   = 3'd2;
   localparam logic [3:0] QP_SHIFT_RESET = 4'd4;

   localparam logic signed [RESULT_W-1:0] RES_MAX = 36'sh7FFFFFFFF;
   localparam logic signed [RESULT_W-1:0] RES_MIN = 36'sh800000000;

   localparam logic [2:0] SCAN_CLASS [16] = '{
      3'd0, 3'd3, 3'd4, 3'd3, 3'd3, 3'd1, 3'd5, 3'd1,
      3'd4, 3'd5, 3'd2, 3'd5, 3'd3, 3'd1, 3'd5, 3'd1
   };

   localparam logic [5:0] DQ_SCALE [6][6] = '{
      '{6'd20, 6'd18, 6'd32, 6'd19, 6'd25, 6'd24},
      '{6'd22, 6'd19, 6'd35, 6'd21, 6'd28, 6'd26},
      '{6'd26, 6'd23, 6'd42, 6'd24, 6'd33, 6'd31},
      '{6'd28, 6'd25, 6'd45, 6'd26, 6'd35, 6'd33},
      '{6'd32, 6'd28, 6'd51, 6'd30, 6'd40, 6'd38},
      '{6'd36, 6'd32, 6'd58, 6'd34, 6'd46, 6'd43}
   };

   localparam logic [14:0] Q_SCALE [6][6] = '{
      '{15'd13107, 15'd11428, 15'd20972, 15'd12222, 15'd16777, 15'd15481},
      '{15'd11916, 15'd10826, 15'd19174, 15'd11058, 15'd14980, 15'd14290},
      '{15'd10082, 15'd8943,  15'd15978, 15'd9675,  15'd12710, 15'd11985},
      '{15'd9362,  15'd8228,  15'd14913, 15'd8931,  15'd11984, 15'd11259},
      '{15'd8192,  15'd7346,  15'd13159, 15'd7740,  15'd10486, 15'd9777},
      '{15'd7282,  15'd6428,  15'd11570, 15'd6830,  15'd9118,  15'd8640}
   };

   // intra weight depends on row+col only, except at row 1, column 1
   localparam logic [5:0] DIAG_WEIGHT [15] = '{
      6'd6,  6'd10, 6'd13, 6'd16, 6'd18, 6'd23, 6'd25, 6'd27,
      6'd29, 6'd31, 6'd33, 6'd36, 6'd38, 6'd40, 6'd42
   };
   localparam logic [5:0] CORNER_WEIGHT = 6'd11;

   // floor(2^24 / weight)
   localparam int RECIP_SHIFT = 24;
   localparam logic [21:0] DIAG_RECIP [15] = '{
      22'd2796202, 22'd1677721, 22'd1290555, 22'd1048576, 22'd932067,
      22'd729444,  22'd671088,  22'd621378,  22'd578524,  22'd541200,
      22'd508400,  22'd466033,  22'd441505,  22'd419430,  22'd399457
   };
   localparam logic [21:0] CORNER_RECIP = 22'd1525201;

   typedef struct packed {
      logic               cmd;
      logic               zero;
      logic               use_matrix;
      logic [3:0]         sh;
      logic signed [18:0] vq;
      logic [5:0]         w;
      logic [18:0]        n;
      logic [21:0]        recip;
      logic [14:0]        qs;
      logic signed [15:0] vd;
      logic [11:0]        dqw;
   } cq8_entry_type;

endpackage

### hw/rtl/cq8_front.sv
// Front end: configuration registers, request transfer and per-item classification.
// Depends on cq8_pkg; feeds the item queue.
`timescale 1ns / 1ps

module cq8_front import cq8_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,
   input  logic                      start,
   input  logic                      queue_full,
   input  logic                      req_cmd,
   input  logic signed [COEFF_W-1:0] req_coeff,
   input  logic [2:0]                req_row,
   input  logic [2:0]                req_col,
   output logic                      busy,
   output logic                      push,
   output cq8_entry_type             entry
);

   logic [2:0]  rem_ff, rem_in;
   logic [3:0]  sh_ff, sh_in;
   logic [3:0]  hb_ff, hb_in;
   logic [3:0]  vb_ff, vb_in;
   logic        um_ff, um_in;
   logic [11:0] qp_mul;
   logic [3:0]  qp_sh;
   logic [5:0]  qp_rem;

   always_comb begin
      rem_in = rem_ff;
      sh_in  = sh_ff;
      hb_in  = hb_ff;
      vb_in  = vb_ff;
      um_in  = um_ff;
      // qp / 6 as (qp * 43) >> 8, exact for 6-bit qp
      qp_mul = 12'(csr_wdata[5:0]) * 12'd43;
      qp_sh  = qp_mul[11:8];
      qp_rem = csr_wdata[5:0] - 6'(qp_sh) * 6'd6;
      if (csr_write) begin
         case (csr_index)
            CSR_QP: begin
               sh_in  = qp_sh;
               rem_in = qp_rem[2:0];
            end
            CSR_H_BLOCKNESS: hb_in = csr_wdata[3:0];
            CSR_V_BLOCKNESS: vb_in = csr_wdata[3:0];
            CSR_USE_MATRIX:  um_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= QP_REM_RESET;
         sh_ff  <= QP_SHIFT_RESET;
         hb_ff  <= '0;
         vb_ff  <= '0;
         um_ff  <= 1'b0;
      end else begin
         rem_ff <= rem_in;
         sh_ff  <= sh_in;
         hb_ff  <= hb_in;
         vb_ff  <= vb_in;
         um_ff  <= um_in;
      end
   end

   assign busy = queue_full;
   assign push = start & ~queue_full;

   logic [2:0]         cls;
   logic [3:0]         diag;
   logic               corner;
   logic               blocked;
   logic [14:0]        qs_tab;
   logic [5:0]         dq;
   logic [5:0]         w;
   logic signed [24:0] c_round;

   always_comb begin
      cls     = SCAN_CLASS[{req_row[1:0], req_col[1:0]}];
      diag    = 4'(req_row) + 4'(req_col);
      corner  = (req_row == 3'd1) && (req_col == 3'd1);
      w       = corner ? CORNER_WEIGHT : DIAG_WEIGHT[diag];
      blocked = (5'(req_col) + 5'(hb_ff) >= 5'd8) || (5'(req_row) + 5'(vb_ff) >= 5'd8);
      qs_tab  = Q_SCALE[rem_ff][cls];
      dq      = DQ_SCALE[rem_ff][cls];
      c_round = 25'(req_coeff) + (req_coeff[COEFF_W-1] ? -25'sd32 : 25'sd32);

      entry.cmd        = req_cmd;
      entry.zero       = (req_coeff == '0);
      entry.use_matrix = um_ff;
      entry.sh         = sh_ff;
      entry.vq         = c_round[24:6];
      entry.w          = w;
      entry.qs         = blocked ? '0 : qs_tab;
      entry.n          = 19'({entry.qs, 4'b0000}) + 19'(w[5:1]);
      entry.recip      = corner ? CORNER_RECIP : DIAG_RECIP[diag];
      entry.dqw        = um_ff ? 12'(dq) * 12'(w) : {2'b00, dq, 4'b0000};
      if (req_coeff > 24'sd32767) begin
         entry.vd = 16'sd32767;
      end else if (req_coeff < -24'sd32768) begin
         entry.vd = -16'sd32768;
      end else begin
         entry.vd = req_coeff[15:0];
      end
   end

endmodule

### hw/rtl/cq8_queue.sv
// Short FIFO of classified items between front and back end.
// Depends on cq8_pkg for the entry type.
`timescale 1ns / 1ps

module cq8_queue import cq8_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cq8_entry_type wr_entry,
   input  logic          pop,
   output cq8_entry_type rd_entry,
   output logic          full,
   output logic          not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cq8_entry_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;
   assign rd_entry  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

### hw/rtl/cq8_back.sv
// Back end: four-stage arithmetic pipeline for quantize and dequantize.
// Depends on cq8_pkg; drains the item queue one entry per cycle.
`timescale 1ns / 1ps

module cq8_back import cq8_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  cq8_entry_type              head,
   output logic                       pop,
   output logic                       rsp_valid,
   output logic signed [RESULT_W-1:0] rsp_result
);

   assign pop = head_valid;

   // stage 1: reciprocal product for the weight division, dequantize product
   logic [40:0]        div_prod;
   logic [16:0]        s1_q0_in;
   logic signed [28:0] vd_ext, dqw_ext, s1_pd_in;

   always_comb begin
      div_prod = 41'(head.n) * 41'(head.recip);
      s1_q0_in = div_prod[40:RECIP_SHIFT];
      vd_ext   = 29'(head.vd);
      dqw_ext  = 29'(head.dqw);
      s1_pd_in = vd_ext * dqw_ext;
   end

   logic               s1_valid_ff;
   logic               s1_cmd_ff, s1_zero_ff, s1_um_ff;
   logic [3:0]         s1_sh_ff;
   logic signed [18:0] s1_vq_ff;
   logic [5:0]         s1_w_ff;
   logic [18:0]        s1_n_ff;
   logic [14:0]        s1_qs_ff;
   logic [16:0]        s1_q0_ff;
   logic signed [28:0] s1_pd_ff;

   // stage 2: quotient correction, dequantize shift and saturation
   logic [22:0]                qw;
   logic [19:0]                rdiff;
   logic [16:0]                qs_div, s2_qs_in;
   logic signed [39:0]         pd_wide, pd_shift;
   logic signed [RESULT_W-1:0] s2_dres_in;

   always_comb begin
      qw       = 23'(s1_q0_ff) * 23'(s1_w_ff);
      rdiff    = 20'(s1_n_ff) - qw[19:0];
      qs_div   = (rdiff >= 20'(s1_w_ff)) ? s1_q0_ff + 17'd1 : s1_q0_ff;
      s2_qs_in = s1_um_ff ? qs_div : 17'(s1_qs_ff);
      pd_wide  = 40'(s1_pd_ff);
      pd_shift = pd_wide <<< s1_sh_ff;
      if (pd_shift > 40'(RES_MAX)) begin
         s2_dres_in = RES_MAX;
      end else if (pd_shift < 40'(RES_MIN)) begin
         s2_dres_in = RES_MIN;
      end else begin
         s2_dres_in = pd_shift[RESULT_W-1:0];
      end
   end

   logic                       s2_valid_ff;
   logic                       s2_cmd_ff, s2_zero_ff;
   logic [3:0]                 s2_sh_ff;
   logic signed [18:0]         s2_vq_ff;
   logic [16:0]                s2_qs_ff;
   logic signed [RESULT_W-1:0] s2_dres_ff;

   // stage 3: level times scale, 19 by 18 bits
   logic signed [17:0]         qs_ext;
   logic signed [RESULT_W-1:0] s3_pq_in;

   always_comb begin
      qs_ext   = signed'({1'b0, s2_qs_ff});
      s3_pq_in = RESULT_W'(s2_vq_ff * qs_ext);
   end

   logic                       s3_valid_ff;
   logic                       s3_cmd_ff, s3_zero_ff;
   logic [3:0]                 s3_sh_ff;
   logic signed [RESULT_W-1:0] s3_pq_ff;
   logic signed [RESULT_W-1:0] s3_dres_ff;

   // stage 4: rounding shift, 16-bit saturation, result select
   logic [36:0]                rnd;
   logic signed [36:0]         rounded, shifted;
   logic signed [15:0]         qres;
   logic signed [RESULT_W-1:0] result_in;

   always_comb begin
      rnd     = 37'd1 << (5'(s3_sh_ff) + 5'd11);
      rounded = 37'(s3_pq_ff) + signed'(rnd);
      shifted = rounded >>> (5'(s3_sh_ff) + 5'd12);
      if (shifted > 37'sd32767) begin
         qres = 16'sd32767;
      end else if (shifted < -37'sd32768) begin
         qres = -16'sd32768;
      end else begin
         qres = shifted[15:0];
      end
      if (s3_cmd_ff == CMD_DEQUANT) begin
         result_in = s3_dres_ff;
      end else if (s3_zero_ff) begin
         result_in = '0;
      end else begin
         result_in = RESULT_W'(qres);
      end
   end

   logic                       rsp_valid_ff;
   logic signed [RESULT_W-1:0] rsp_result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= head_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff     <= head.cmd;
      s1_zero_ff    <= head.zero;
      s1_um_ff      <= head.use_matrix;
      s1_sh_ff      <= head.sh;
      s1_vq_ff      <= head.vq;
      s1_w_ff       <= head.w;
      s1_n_ff       <= head.n;
      s1_qs_ff      <= head.qs;
      s1_q0_ff      <= s1_q0_in;
      s1_pd_ff      <= s1_pd_in;

      s2_cmd_ff     <= s1_cmd_ff;
      s2_zero_ff    <= s1_zero_ff;
      s2_sh_ff      <= s1_sh_ff;
      s2_vq_ff      <= s1_vq_ff;
      s2_qs_ff      <= s2_qs_in;
      s2_dres_ff    <= s2_dres_in;

      s3_cmd_ff     <= s2_cmd_ff;
      s3_zero_ff    <= s2_zero_ff;
      s3_sh_ff      <= s2_sh_ff;
      s3_pq_ff      <= s3_pq_in;
      s3_dres_ff    <= s2_dres_ff;

      rsp_result_ff <= result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule

### hw/rtl/coefficient_quantizer_8x8.sv
// 8x8 coefficient quantizer/dequantizer top: front end, item queue, back end.
// Path: the queue stores the item, then registers s1, s2, s3 and the result register carry it.
// One item per cycle: queued items pop at once, so busy stays low when QUEUE_DEPTH exceeds 1.
// Result strobe lasts one cycle; the receiver cannot stall.
// Reset (synchronous): qp 26, blockness 0, matrix off; queue and pipeline emptied.
// Depends on cq8_pkg, cq8_front, cq8_queue, cq8_back.
`timescale 1ns / 1ps

module coefficient_quantizer_8x8 import cq8_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_cmd,
   input  logic signed [COEFF_W-1:0]  req_coeff,
   input  logic [2:0]                 req_row,
   input  logic [2:0]                 req_col,
   output logic                       rsp_valid,
   output logic signed [RESULT_W-1:0] rsp_result,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   cq8_entry_type push_entry, head_entry;
   logic          push, pop, queue_full, head_valid;

   assign csr_ready = 1'b1;

   cq8_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid & csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .start      (start),
      .queue_full (queue_full),
      .req_cmd    (req_cmd),
      .req_coeff  (req_coeff),
      .req_row    (req_row),
      .req_col    (req_col),
      .busy       (busy),
      .push       (push),
      .entry      (push_entry)
   );

   cq8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_entry  (push_entry),
      .pop       (pop),
      .rd_entry  (head_entry),
      .full      (queue_full),
      .not_empty (head_valid)
   );

   cq8_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

endmodule

### hw/rtl/cq8_checker.sv
// Port-level checker for the 8x8 coefficient quantizer, bound to the top level.
// Depends on cq8_pkg and coefficient_quantizer_8x8_macros.svh.
`timescale 1ns / 1ps
`include "coefficient_quantizer_8x8_macros.svh"

module cq8_checker import cq8_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       req_cmd,
   input logic signed [COEFF_W-1:0]  req_coeff,
   input logic                       rsp_valid,
   input logic signed [RESULT_W-1:0] rsp_result
);

   logic xfer, quant_xfer, zero_xfer, level_fits, rsp_zero;

   assign xfer       = start && !busy;
   assign quant_xfer = xfer && (req_cmd == CMD_QUANT);
   assign zero_xfer  = xfer && (req_coeff == '0);
   assign level_fits = (rsp_result[35:15] == '0) || (rsp_result[35:15] == '1);
   assign rsp_zero   = (rsp_result == '0);

   // each transfer is followed by its result strobe, and no strobe comes without a transfer
   `CQ8_ASSERT(a_transfer_to_rsp, clock, reset, xfer |-> ##5 rsp_valid, "no result for item")
   `CQ8_ASSERT(a_no_extra_rsp, clock, reset, !xfer |-> ##5 !rsp_valid, "result without an item")
   `CQ8_NEVER(a_never_busy, clock, reset, busy, "busy while back end drains every cycle")
   `CQ8_ASSERT(a_quant_range, clock, reset, quant_xfer |-> ##5 level_fits, "level past 16 bits")
   `CQ8_ASSERT(a_zero_in_zero_out, clock, reset, zero_xfer |-> ##5 rsp_zero, "zero in, nonzero out")

endmodule

bind coefficient_quantizer_8x8 cq8_checker u_cq8_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_cmd    (req_cmd),
   .req_coeff  (req_coeff),
   .rsp_valid  (rsp_valid),
   .rsp_result (rsp_result)
);
